// File: rtl/pmes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmes_pkg
// Shared types and constants of the pairwise Morse sum core.
// ----------------------------------------------------------------------------
package pmes_pkg;

    localparam int MAX_PARTICLES_DEF = 32;

    localparam int POS_W      = 24;
    localparam int DEPTH_W    = 24;
    localparam int ACC_W      = 48;
    localparam int RHO_W      = 16;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int LN2_Q16    = 45426;
    localparam int DIV_W      = 31;
    localparam int TERMS      = 10;
    localparam int SQRT_BITS  = 26;
    localparam int KSTEP_BITS = 6;

    localparam logic [1:0] REQ_LOAD_POS  = 2'd0;
    localparam logic [1:0] REQ_LOAD_PAIR = 2'd1;
    localparam logic [1:0] REQ_SUM       = 2'd2;

    localparam logic [0:0] REG_PARTICLE_COUNT = 1'b0;
    localparam logic [0:0] REG_RANGE_RHO      = 1'b1;

    localparam logic [RHO_W-1:0] RHO_RESET = 16'd1536;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [IDX_W-1:0]         index_a;
        logic [IDX_W-1:0]         index_b;
        logic signed [POS_W-1:0]  x_coord;
        logic signed [POS_W-1:0]  y_coord;
        logic                     bonded;
        logic signed [DEPTH_W-1:0] well_depth;
    } t_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] energy_sum;
        logic                    saturated;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_I, ST_RD_J, ST_CAP_J, ST_SQX, ST_SQY, ST_SQRT, ST_ARG,
        ST_RANGE, ST_KSTEP, ST_TMUL, ST_DIVS, ST_DIVW, ST_TADD, ST_YSHIFT,
        ST_YSQ, ST_WCALC, ST_MH, ST_ML, ST_MAG, ST_ACC, ST_NEXT, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_CAP_I, OP_CAP_J, OP_SQX, OP_SQY, OP_SQRT, OP_ARG,
        OP_RANGE, OP_KSTEP, OP_TMUL, OP_DIVS, OP_TADD, OP_YSHIFT, OP_YSQ,
        OP_WCALC, OP_MH, OP_ML, OP_MAG, OP_ACC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic [3:0] term_n;
    } t_cmd;

    typedef struct packed {
        logic bonded;
        logic in_range;
        logic div_busy;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/pmes_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmes_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pmes_ram #(
    parameter int WIDTH = 2 * pmes_pkg::POS_W,
    parameter int DEPTH = pmes_pkg::MAX_PARTICLES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/pmes_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmes_div
// Divide by a small constant (1 to 10): reciprocal multiply, one correction.
// ----------------------------------------------------------------------------
module pmes_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pmes_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [3:0]                  i_divisor,
    output logic                             o_busy,
    output logic      [pmes_pkg::DIV_W-1:0]  o_quot
);
    import pmes_pkg::*;

    logic                r_busy;
    logic [DIV_W-1:0]    r_dvd;
    logic [3:0]          r_d;
    logic [DIV_W-1:0]    r_est;
    logic [31:0]         recip;
    logic [DIV_W+31:0]   prod;
    logic [DIV_W+3:0]    back;
    logic [DIV_W+3:0]    rem;

    // floor(2^32 / d), and 2^32 - 1 for d = 1; the estimate is low by at most one
    always_comb begin
        case (r_d)
            4'd1:    recip = 32'hFFFF_FFFF;
            4'd2:    recip = 32'h8000_0000;
            4'd3:    recip = 32'h5555_5555;
            4'd4:    recip = 32'h4000_0000;
            4'd5:    recip = 32'h3333_3333;
            4'd6:    recip = 32'h2AAA_AAAA;
            4'd7:    recip = 32'h2492_4924;
            4'd8:    recip = 32'h2000_0000;
            4'd9:    recip = 32'h1C71_C71C;
            4'd10:   recip = 32'h1999_9999;
            default: recip = '0;
        endcase
    end

    assign prod = (DIV_W+32)'(r_dvd) * (DIV_W+32)'(recip);
    assign back = (DIV_W+4)'(r_est) * (DIV_W+4)'(r_d);
    assign rem  = {4'd0, r_dvd} - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_est <= prod[DIV_W+31:32];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_est + DIV_W'(rem >= (DIV_W+4)'(r_d));

endmodule
`default_nettype wire

// File: rtl/pmes_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmes_dp
// Datapath: position and pair stores, distance, exponential, term, accumulator.
// ----------------------------------------------------------------------------
module pmes_dp #(
    parameter int MAX_PARTICLES = pmes_pkg::MAX_PARTICLES_DEF,
    localparam int IW = $clog2(MAX_PARTICLES)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire pmes_pkg::t_item               i_item,
    input  wire logic [pmes_pkg::RHO_W-1:0]    i_range_rho,
    input  wire pmes_pkg::t_cmd                i_cmd,
    input  wire logic [IW-1:0]                 i_pos_raddr,
    input  wire logic [2*IW-1:0]               i_pair_raddr,
    output pmes_pkg::t_stat                    o_stat,
    output pmes_pkg::t_result                  o_result
);
    import pmes_pkg::*;

    localparam int PAIR_DEPTH = 1 << (2 * IW);
    localparam logic signed [35:0] X_HI  = 36'(16 * LN2_Q16);
    localparam logic signed [35:0] X_LO  = 36'(-48 * LN2_Q16);
    localparam logic signed [35:0] X_OFS = 36'(48 * LN2_Q16);
    localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;
    localparam logic signed [49:0] ACC_MAX_X = $signed({3'b000, {47{1'b1}}});
    localparam logic signed [49:0] ACC_MIN_X = $signed({3'b111, 47'd0});

    // ---- stores ----
    logic [IDX_W-1:0] pair_lo, pair_hi;
    logic             pos_we, pair_we;
    logic [47:0]      pos_rdata;
    logic [24:0]      pair_rdata;

    always_comb begin
        if (i_item.index_a < i_item.index_b) begin
            pair_lo = i_item.index_a;
            pair_hi = i_item.index_b;
        end else begin
            pair_lo = i_item.index_b;
            pair_hi = i_item.index_a;
        end
        pos_we  = i_accept && (i_item.req_type == REQ_LOAD_POS)
                  && (32'(i_item.index_a) < MAX_PARTICLES);
        pair_we = i_accept && (i_item.req_type == REQ_LOAD_PAIR)
                  && (32'(pair_hi) < MAX_PARTICLES);
    end

    pmes_ram #(.WIDTH(48), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (IW'(i_item.index_a)),
        .i_wdata ({i_item.x_coord, i_item.y_coord}),
        .i_raddr (i_pos_raddr),
        .o_rdata (pos_rdata)
    );

    pmes_ram #(.WIDTH(25), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr ({IW'(pair_hi), IW'(pair_lo)}),
        .i_wdata ({i_item.bonded, i_item.well_depth}),
        .i_raddr (i_pair_raddr),
        .o_rdata (pair_rdata)
    );

    // ---- registers ----
    logic signed [23:0] r_xi, r_yi, r_e;
    logic               r_bond;
    logic signed [24:0] r_dx, r_dy;
    logic [49:0]        r_r2;
    logic [25:0]        r_root;
    logic signed [35:0] r_xa;
    logic [21:0]        r_f;
    logic [5:0]         r_k;
    logic [30:0]        r_term, r_prod;
    logic [31:0]        r_sum, r_y, r_p;
    logic [63:0]        r_yy, r_pl;
    logic [47:0]        r_aw, r_ph;
    logic               r_wneg, r_tneg;
    logic [48:0]        r_mag;
    logic signed [47:0] r_acc;
    logic               r_sat;

    // ---- combinational helpers ----
    logic [24:0]        adx, ady;
    logic [25:0]        sq_c;
    logic               sq_ok;
    logic signed [26:0] rdiff;
    logic signed [43:0] arg_prod;
    logic               in_range;
    logic [21:0]        kcmp;
    logic [46:0]        tm_full;
    logic signed [7:0]  ke;
    logic [32:0]        y_wide;
    logic signed [48:0] w_val;
    logic [23:0]        abs_e;
    logic [39:0]        p_full;
    logic [49:0]        mag_sum;
    logic signed [49:0] acc_sum;
    logic [DIV_W-1:0]   quot;
    logic               div_busy;

    assign adx      = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign ady      = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign sq_c     = r_root | (26'd1 << i_cmd.step);
    assign sq_ok    = (52'(sq_c) * 52'(sq_c)) <= 52'(r_r2);
    assign rdiff    = $signed({1'b0, r_root}) - 27'sd65536;
    assign arg_prod = 44'($signed({1'b0, i_range_rho})) * 44'(rdiff);
    assign in_range = (r_xa < X_HI) && (r_xa >= X_LO);
    assign kcmp     = 22'(LN2_Q16) << i_cmd.step;
    assign tm_full  = 47'(r_term) * 47'(r_f[15:0]);
    assign ke       = $signed({2'b00, r_k}) - 8'sd48;
    assign w_val    = $signed({1'b0, r_yy[63:16]}) - $signed({17'd0, r_y});
    assign abs_e    = r_e[23] ? 24'(-r_e) : 24'(r_e);
    assign p_full   = 40'(i_range_rho) * 40'(abs_e);
    assign mag_sum  = (50'(r_ph) << 17) + 50'(r_pl[63:15]);
    assign acc_sum  = 50'(r_acc)
                      + (r_tneg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag}));

    // Y = series value scaled by 2^(k-14)
    always_comb begin
        if (ke > 8'sd14) begin
            y_wide = {r_sum, 1'b0};
        end else if (ke == 8'sd14) begin
            y_wide = {1'b0, r_sum};
        end else begin
            y_wide = {1'b0, r_sum} >> 6'(8'sd14 - ke);
        end
    end

    pmes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIVS),
        .i_dividend (r_prod),
        .i_divisor  (i_cmd.term_n),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_acc <= '0;
                    r_sat <= 1'b0;
                end
                OP_ACC: begin
                    if (acc_sum > ACC_MAX_X) begin
                        r_acc <= 48'(ACC_MAX_X);
                        r_sat <= 1'b1;
                    end else if (acc_sum < ACC_MIN_X) begin
                        r_acc <= 48'(ACC_MIN_X);
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= 48'(acc_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP_I: begin
                r_xi   <= pos_rdata[47:24];
                r_yi   <= pos_rdata[23:0];
                r_bond <= pair_rdata[24];
                r_e    <= pair_rdata[23:0];
            end
            OP_CAP_J: begin
                r_dx <= 25'(r_xi) - 25'($signed(pos_rdata[47:24]));
                r_dy <= 25'(r_yi) - 25'($signed(pos_rdata[23:0]));
            end
            OP_SQX: r_r2 <= 50'(adx) * 50'(adx);
            OP_SQY: begin
                r_r2   <= r_r2 + 50'(ady) * 50'(ady);
                r_root <= '0;
            end
            OP_SQRT: begin
                if (sq_ok) begin
                    r_root <= sq_c;
                end
            end
            OP_ARG: r_xa <= 36'(-(arg_prod >>> 8));
            OP_RANGE: begin
                r_p    <= p_full[39:8];
                r_f    <= 22'(r_xa + X_OFS);
                r_k    <= '0;
                r_sum  <= 32'h4000_0000;
                r_term <= 31'h4000_0000;
                // exp saturates high or flushes to zero outside the table range
                if (r_xa >= X_HI) begin
                    r_y <= '1;
                end else if (r_xa < X_LO) begin
                    r_y <= '0;
                end
            end
            OP_KSTEP: begin
                if (r_f >= kcmp) begin
                    r_f               <= r_f - kcmp;
                    r_k[i_cmd.step[2:0]] <= 1'b1;
                end
            end
            OP_TMUL: r_prod <= tm_full[46:16];
            OP_TADD: begin
                r_term <= quot;
                r_sum  <= r_sum + 32'(quot);
            end
            OP_YSHIFT: r_y <= y_wide[32] ? '1 : y_wide[31:0];
            OP_YSQ: r_yy <= 64'(r_y) * 64'(r_y);
            OP_WCALC: begin
                r_wneg <= w_val[48];
                r_aw   <= w_val[48] ? 48'(-w_val) : 48'(w_val);
            end
            OP_MH: r_ph <= 48'(r_p) * 48'(r_aw[47:32]);
            OP_ML: r_pl <= 64'(r_p) * 64'(r_aw[31:0]);
            OP_MAG: begin
                r_tneg <= r_e[23] == r_wneg;
                if ((r_ph >= 48'h8000_0000) || (mag_sum > 50'(TERM_CAP))) begin
                    r_mag <= TERM_CAP;
                end else begin
                    r_mag <= 49'(mag_sum);
                end
            end
            default: ;
        endcase
    end

    assign o_stat.bonded    = r_bond;
    assign o_stat.in_range  = in_range;
    assign o_stat.div_busy  = div_busy;
    assign o_result.energy_sum = r_acc;
    assign o_result.saturated  = r_sat;

endmodule
`default_nettype wire

// File: rtl/pmes_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmes_ctrl
// Sequencer: walks the pairs and steps the datapath through one pair term.
// ----------------------------------------------------------------------------
module pmes_ctrl #(
    parameter int MAX_PARTICLES = pmes_pkg::MAX_PARTICLES_DEF,
    localparam int IW = $clog2(MAX_PARTICLES),
    localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [pmes_pkg::CNT_W-1:0] i_particle_count,
    input  wire pmes_pkg::t_stat            i_stat,
    output pmes_pkg::t_cmd                  o_cmd,
    output logic      [IW-1:0]              o_pos_raddr,
    output logic      [2*IW-1:0]            o_pair_raddr,
    output logic                            o_busy,
    output logic                            o_done
);
    import pmes_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [4:0]    r_step, n_step;
    logic [3:0]    r_tn, n_tn;
    logic [CW-1:0] n_lim;
    logic [CW:0]   j_inc, i_inc2;
    logic          start_sum;

    assign n_lim = (32'(i_particle_count) > MAX_PARTICLES) ? CW'(MAX_PARTICLES)
                                                           : CW'(i_particle_count);
    assign j_inc     = {1'b0, r_j} + 1'b1;
    assign i_inc2    = {1'b0, r_i} + 2'd2;
    assign start_sum = i_accept && (i_req_type == REQ_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_step  <= '0;
            r_tn    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_step  <= n_step;
            r_tn    <= n_tn;
        end
    end

    // next state and loop counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_step  = r_step;
        n_tn    = r_tn;
        unique case (r_state)
            ST_IDLE: begin
                if (start_sum) begin
                    n_i     = '0;
                    n_j     = CW'(1);
                    n_state = (n_lim < CW'(2)) ? ST_DONE : ST_RD_I;
                end
            end
            ST_RD_I:  n_state = ST_RD_J;
            ST_RD_J:  n_state = ST_CAP_J;
            ST_CAP_J: n_state = i_stat.bonded ? ST_SQX : ST_NEXT;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY: begin
                n_step  = 5'(SQRT_BITS - 1);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_step == '0) begin
                    n_state = ST_ARG;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_ARG: n_state = ST_RANGE;
            ST_RANGE: begin
                n_step  = 5'(KSTEP_BITS - 1);
                n_state = i_stat.in_range ? ST_KSTEP : ST_YSQ;
            end
            ST_KSTEP: begin
                if (r_step == '0) begin
                    n_tn    = 4'd1;
                    n_state = ST_TMUL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_TMUL: n_state = ST_DIVS;
            ST_DIVS: n_state = ST_DIVW;
            ST_DIVW: n_state = i_stat.div_busy ? ST_DIVW : ST_TADD;
            ST_TADD: begin
                if (r_tn == 4'(TERMS)) begin
                    n_state = ST_YSHIFT;
                end else begin
                    n_tn    = r_tn + 1'b1;
                    n_state = ST_TMUL;
                end
            end
            ST_YSHIFT: n_state = ST_YSQ;
            ST_YSQ:    n_state = ST_WCALC;
            ST_WCALC:  n_state = ST_MH;
            ST_MH:     n_state = ST_ML;
            ST_ML:     n_state = ST_MAG;
            ST_MAG:    n_state = ST_ACC;
            ST_ACC:    n_state = ST_NEXT;
            ST_NEXT: begin
                if (j_inc < {1'b0, n_lim}) begin
                    n_j     = CW'(j_inc);
                    n_state = ST_RD_I;
                end else if (i_inc2 < {1'b0, n_lim}) begin
                    n_i     = r_i + 1'b1;
                    n_j     = CW'(i_inc2);
                    n_state = ST_RD_I;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.step   = r_step;
        o_cmd.term_n = r_tn;
        o_pos_raddr  = (r_state == ST_RD_J) ? r_j[IW-1:0] : r_i[IW-1:0];
        o_pair_raddr = {r_j[IW-1:0], r_i[IW-1:0]};
        o_busy       = r_state != ST_IDLE;
        o_done       = r_state == ST_DONE;
        unique case (r_state)
            ST_IDLE:   o_cmd.op = start_sum ? OP_CLEAR : OP_NONE;
            ST_RD_J:   o_cmd.op = OP_CAP_I;
            ST_CAP_J:  o_cmd.op = OP_CAP_J;
            ST_SQX:    o_cmd.op = OP_SQX;
            ST_SQY:    o_cmd.op = OP_SQY;
            ST_SQRT:   o_cmd.op = OP_SQRT;
            ST_ARG:    o_cmd.op = OP_ARG;
            ST_RANGE:  o_cmd.op = OP_RANGE;
            ST_KSTEP:  o_cmd.op = OP_KSTEP;
            ST_TMUL:   o_cmd.op = OP_TMUL;
            ST_DIVS:   o_cmd.op = OP_DIVS;
            ST_TADD:   o_cmd.op = OP_TADD;
            ST_YSHIFT: o_cmd.op = OP_YSHIFT;
            ST_YSQ:    o_cmd.op = OP_YSQ;
            ST_WCALC:  o_cmd.op = OP_WCALC;
            ST_MH:     o_cmd.op = OP_MH;
            ST_ML:     o_cmd.op = OP_ML;
            ST_MAG:    o_cmd.op = OP_MAG;
            ST_ACC:    o_cmd.op = OP_ACC;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_sum_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_sum |=> o_busy)
        else $error("start of sum did not make the block busy");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE) |-> (r_j > r_i))
        else $error("pair walk left i < j");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TADD) |-> !i_stat.div_busy)
        else $error("series term taken before divide finished");
`endif

endmodule
`default_nettype wire

// File: rtl/pairwise_morse_energy_sum_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_morse_energy_sum_core
// Fixed-point Morse pair sum over up to MAX_PARTICLES 2D particles.
// ----------------------------------------------------------------------------
// Load items (position, pair parameters) are taken one per cycle while busy is
// low and may be issued back to back. A sum item holds busy high while the
// sequencer walks all pairs i<j: an unbonded pair is skipped once its bond flag
// is read; a bonded pair runs a 26-step square root and, when the exponent is in
// range, a 6-step range reduction and ten series terms, each built around a
// reciprocal divide; these two are passed over when the exponent saturates. The
// result is then shown on o_result with o_done high for exactly one cycle; the
// receiver must take it then. There is no clearing pass; stores must be written before they are used.
// ----------------------------------------------------------------------------
module pairwise_morse_energy_sum_core #(
    parameter int MAX_PARTICLES = pmes_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pmes_pkg::t_item   i_item,
    output logic                   o_done,
    output pmes_pkg::t_result      o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    import pmes_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);

    logic [CNT_W-1:0] r_particle_count;
    logic [RHO_W-1:0] r_range_rho;
    logic             accept;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;
    logic [IW-1:0]    pos_raddr;
    logic [2*IW-1:0]  pair_raddr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_particle_count <= '0;
            r_range_rho      <= RHO_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PARTICLE_COUNT: r_particle_count <= pwdata[CNT_W-1:0];
                REG_RANGE_RHO:      r_range_rho      <= pwdata[RHO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PARTICLE_COUNT: prdata = 32'(r_particle_count);
            REG_RANGE_RHO:      prdata = 32'(r_range_rho);
            default:            prdata = '0;
        endcase
    end

    pmes_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_req_type       (i_item.req_type),
        .i_particle_count (r_particle_count),
        .i_stat           (stat),
        .o_cmd            (cmd),
        .o_pos_raddr      (pos_raddr),
        .o_pair_raddr     (pair_raddr),
        .o_busy           (busy),
        .o_done           (o_done)
    );

    pmes_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .i_range_rho  (r_range_rho),
        .i_cmd        (cmd),
        .i_pos_raddr  (pos_raddr),
        .i_pair_raddr (pair_raddr),
        .o_stat       (stat),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire

// File: sim/pairwise_morse_energy_sum_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_morse_energy_sum_core_tb
// Drives position, pair and sum items into the Morse pair sum core and checks
// every sum against a fixed-point predictor of the pair walk. The particle
// count and range rho are changed between phases, with sender idling varied.
// ----------------------------------------------------------------------------
module pairwise_morse_energy_sum_core_tb;
    import pmes_pkg::*;

    localparam int NPART    = 32;
    localparam int LN2      = 45426;
    localparam int WD_LIMIT = 1000000;
    localparam longint unsigned Y_SAT = 64'hFFFF_FFFF;
    localparam longint TERM_LIM = 64'sd1 <<< 48;
    localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< 47);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_done;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pairwise_morse_energy_sum_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state, updated as items are accepted
    int          pos_x [NPART];
    int          pos_y [NPART];
    bit          bond_tbl [NPART][NPART];
    int          depth_tbl [NPART][NPART];
    logic [5:0]  cnt_cfg = 6'd0;
    logic [15:0] rho_cfg = RHO_RESET;

    t_item   item_q [$];
    t_result sum_q [$];
    int      idle_pct = 0;
    int      mismatches = 0;
    int      wd_cnt = 0;

    // stimulus-side bookkeeping: which store entries have been written
    bit pos_ready [NPART];
    bit pair_ready [NPART][NPART];

    function automatic longint morse_term(longint dx, longint dy, int e, int rho);
        longint unsigned r2, r, c, y, srs, trm, ae, p, aw, wh, wl, mag;
        longint a, x, k, f, w;
        r2 = longint'(dx * dx) + longint'(dy * dy);
        r = 0;
        for (int b = 25; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= r2) r = c;
        end
        a = (longint'(rho) * (longint'(r) - 65536)) >>> 8;
        x = -a;
        if (x >= 0) k = x / LN2;
        else k = -((-x + LN2 - 1) / LN2);
        if (k >= 16) begin
            y = Y_SAT;
        end else if (k < -48) begin
            y = 0;
        end else begin
            f = x - k * LN2;
            srs = 64'd1 << 30;
            trm = 64'd1 << 30;
            for (int n = 1; n <= 10; n++) begin
                trm = ((trm * longint'(f)) >> 16) / n;
                srs += trm;
            end
            if (k >= 14) y = srs << (k - 14);
            else y = srs >> (14 - k);
            if (y > Y_SAT) y = Y_SAT;
        end
        w = longint'((y * y) >> 16) - longint'(y);
        ae = (e < 0) ? -longint'(e) : longint'(e);
        p = (longint'(rho) * ae) >> 8;
        aw = (w < 0) ? -w : w;
        wh = aw >> 32;
        wl = aw & 64'hFFFF_FFFF;
        if (p * wh >= (64'd1 << 31)) begin
            mag = TERM_LIM;
        end else begin
            mag = ((p * wh) << 17) + ((p * wl) >> 15);
            if (mag > TERM_LIM) mag = TERM_LIM;
        end
        return ((e < 0) == (w < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    task automatic apply_item(t_item it);
        int lo, hi, n;
        longint acc, s;
        bit sat;
        t_result res;
        case (it.req_type)
            REQ_LOAD_POS: begin
                pos_x[it.index_a] = it.x_coord;
                pos_y[it.index_a] = it.y_coord;
            end
            REQ_LOAD_PAIR: begin
                lo = (it.index_a < it.index_b) ? it.index_a : it.index_b;
                hi = (it.index_a < it.index_b) ? it.index_b : it.index_a;
                bond_tbl[hi][lo] = it.bonded;
                depth_tbl[hi][lo] = it.well_depth;
            end
            REQ_SUM: begin
                n = (cnt_cfg > NPART) ? NPART : cnt_cfg;
                acc = 0;
                sat = 1'b0;
                for (int i = 0; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (bond_tbl[j][i]) begin
                            s = acc + morse_term(longint'(pos_x[i]) - pos_x[j],
                                                 longint'(pos_y[i]) - pos_y[j],
                                                 depth_tbl[j][i], rho_cfg);
                            if (s > SUM_HI) begin s = SUM_HI; sat = 1'b1; end
                            if (s < SUM_LO) begin s = SUM_LO; sat = 1'b1; end
                            acc = s;
                        end
                res.energy_sum = acc[47:0];
                res.saturated = sat;
                sum_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_item nxt;
        logic  launch;
        nxt = i_item;
        launch = start;
        if (i_rst_n && start && !busy) begin
            apply_item(i_item);
            launch = 1'b0;
        end
        if (i_rst_n && !launch && item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt = item_q.pop_front();
            launch = 1'b1;
        end
        start <= launch;
        i_item <= nxt;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sum_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected sum %h sat %b", o_result.energy_sum,
                             o_result.saturated);
            end else begin
                t_result exp_r;
                exp_r = sum_q.pop_front();
                if (o_result.energy_sum !== exp_r.energy_sum ||
                    o_result.saturated !== exp_r.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: sum exp %h sat %b, got %h sat %b",
                                 exp_r.energy_sum, exp_r.saturated,
                                 o_result.energy_sum, o_result.saturated);
                end
            end
        end
    end

    // watchdog: stalls with work pending
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done) begin
            wd_cnt <= 0;
        end else if (start || busy || item_q.size() > 0 || sum_q.size() > 0) begin
            wd_cnt <= wd_cnt + 1;
            if (wd_cnt >= WD_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_PARTICLE_COUNT) cnt_cfg = val[5:0];
        else rho_cfg = val[15:0];
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (item_q.size() > 0 || start || busy || sum_q.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom_range(262143)) - 24'd131072;
        endcase
    endfunction

    function automatic t_item rand_item(logic [1:0] rt);
        t_item       it;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[$bits(t_item)-1:0];
        it.req_type = rt;
        return it;
    endfunction

    task automatic push_pos(int idx, logic [23:0] x, logic [23:0] y);
        t_item it;
        it = rand_item(REQ_LOAD_POS);
        it.index_a = 5'(idx); it.x_coord = x; it.y_coord = y;
        item_q.push_back(it);
        pos_ready[idx] = 1'b1;
    endtask

    task automatic push_pair(int a, int b, bit bnd, logic [23:0] e);
        t_item it;
        it = rand_item(REQ_LOAD_PAIR);
        it.index_a = 5'(a); it.index_b = 5'(b); it.bonded = bnd; it.well_depth = e;
        item_q.push_back(it);
        pair_ready[(a > b) ? a : b][(a > b) ? b : a] = 1'b1;
    endtask

    function automatic logic [23:0] rand_depth();
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom_range(131071)) - 24'd65536;
        endcase
    endfunction

    // every store entry a sum reads must be written first
    task automatic push_sum(int n);
        for (int i = 0; i < n; i++) begin
            if (!pos_ready[i]) push_pos(i, rand_coord(), rand_coord());
            for (int j = 0; j < i; j++)
                if (!pair_ready[i][j])
                    push_pair(i, j, (n > 8) ? ($urandom_range(15) == 0)
                                            : 1'($urandom_range(1)),
                              rand_depth());
        end
        item_q.push_back(rand_item(REQ_SUM));
    endtask

    int cnt_list [9] = '{4, 2, 32, 0, 1, 5, 3, 6, 8};
    int rho_list [9] = '{1536, 65535, 256, 0, 1536, -1, 768, 65535, -1};

    initial begin
        int n, sums, base, a, b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = (ph < 3) ? 12 : ((ph < 6) ? 72 : 0);
            n = cnt_list[ph];
            reg_write(REG_PARTICLE_COUNT, n);
            reg_write(REG_RANGE_RHO, (rho_list[ph] < 0) ? $urandom_range(65535) : rho_list[ph]);
            if (ph == 0) begin
                // extremes, coincident particles, swapped and equal pair indices
                push_pos(0, 24'h7FFFFF, 24'h7FFFFF);
                push_pos(1, 24'h800000, 24'h800000);
                push_pos(2, 24'h000000, 24'h000000);
                push_pos(3, 24'h000000, 24'h000000);
                push_pos(31, 24'h010000, 24'hFF0000);
                push_pair(1, 0, 1'b1, 24'h7FFFFF);
                push_pair(0, 2, 1'b1, 24'h800000);
                push_pair(3, 2, 1'b1, 24'h010000);
                push_pair(1, 2, 1'b0, 24'h000000);
                push_pair(0, 3, 1'b1, 24'hFF0000);
                push_pair(3, 1, 1'b1, 24'h7FFFFF);
                push_pair(5, 5, 1'b1, 24'h123456);
                push_pair(31, 30, 1'b1, 24'h800000);
                item_q.push_back(rand_item(2'd3));
                push_sum(n);
                push_pos(3, 24'h010000, 24'h000000);  // unit distance
                push_pair(2, 3, 1'b1, 24'hFF0000);
                push_sum(n);
            end
            sums = 0;
            base = item_q.size();
            while (item_q.size() - base < 220) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        if (n > 0)
                            repeat ($urandom_range(3)) push_pos($urandom_range(n - 1),
                                                                rand_coord(), rand_coord());
                        if (n > 1)
                            repeat ($urandom_range(3)) begin
                                a = $urandom_range(n - 1);
                                b = $urandom_range(n - 1);
                                if (a != b) push_pair(a, b, 1'($urandom_range(1)),
                                                      rand_depth());
                            end
                        if (n <= 8 || sums < 3) begin
                            push_sum(n);
                            sums++;
                        end
                    end
                    6: item_q.push_back(rand_item(2'd3));
                    7: push_pos($urandom_range(31), rand_coord(), rand_coord());
                    8: push_pair($urandom_range(31), $urandom_range(31),
                                 (n > 8) ? 1'b0 : 1'($urandom_range(1)), rand_depth());
                    default: if (n <= 8) push_sum(n);
                endcase
            end
            drain();
        end
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && sum_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: pairwise_morse_energy_sum_core.f
rtl/pmes_pkg.sv
rtl/pmes_ram.sv
rtl/pmes_div.sv
rtl/pmes_dp.sv
rtl/pmes_ctrl.sv
rtl/pairwise_morse_energy_sum_core.sv
sim/pairwise_morse_energy_sum_core_tb.sv
